// ===== src/tse_pkg.sv =====
package tse_pkg;

  // Graph sizes.
  localparam int MAX_NODES  = 63;
  localparam int NODE_SLOTS = 64;
  localparam int NODE_W     = 6;
  localparam int MAX_EDGES  = 128;
  localparam int EIDX_W     = $clog2(MAX_EDGES);
  localparam int ELINK_W    = $clog2(MAX_EDGES + 1);
  localparam int CNT_W      = 8;
  localparam int CNT_MAX    = 255;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [EIDX_W-1:0]  eidx_t;
  typedef logic [ELINK_W-1:0] elink_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Requests from the sequencer to the tables.
  typedef struct packed {
    node_t  pc_raddr;
    logic   pc_we;
    node_t  pc_waddr;
    cnt_t   pc_wdata;
    node_t  lh_raddr;
    logic   lh_we;
    node_t  lh_waddr;
    elink_t lh_wdata;
    eidx_t  eg_raddr;
    logic   eg_we;
    eidx_t  eg_waddr;
    node_t  et_wdata;
    elink_t en_wdata;
    node_t  ql_raddr;
    logic   ql_we;
    node_t  ql_waddr;
    node_t  ql_wdata;
    node_t  scan_addr;
    logic   clear;
  } tbl_req_t;

  // Read data returned by the tables, registered from the address; scan_zero is combinational.
  typedef struct packed {
    cnt_t   pc_rdata;
    elink_t lh_rdata;
    node_t  et_rdata;
    elink_t en_rdata;
    node_t  ql_rdata;
    logic   scan_zero;
  } tbl_rsp_t;

endpackage

// ===== src/tse_tables.sv =====
module tse_tables (
  input  logic              clk,
  input  logic              rst,
  input  tse_pkg::tbl_req_t req,
  output tse_pkg::tbl_rsp_t rsp
);
  import tse_pkg::*;

  cnt_t   pc_mem [NODE_SLOTS];
  elink_t lh_mem [NODE_SLOTS];
  node_t  et_mem [MAX_EDGES];
  elink_t en_mem [MAX_EDGES];
  node_t  ql_mem [NODE_SLOTS];

  logic [NODE_SLOTS-1:0] pc_vld;
  logic [NODE_SLOTS-1:0] lh_vld;

  cnt_t   pc_rd;
  logic   pc_rv;
  elink_t lh_rd;
  logic   lh_rv;
  node_t  et_rd;
  elink_t en_rd;
  node_t  ql_rd;

  // Entry valid bits: a count or list head entry that has not been written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      pc_vld <= '0;
      lh_vld <= '0;
    end else begin
      if (req.pc_we) begin
        pc_vld[req.pc_waddr] <= 1'b1;
      end
      if (req.lh_we) begin
        lh_vld[req.lh_waddr] <= 1'b1;
      end
    end
  end

  // Predecessor counts.
  always_ff @(posedge clk) begin
    if (req.pc_we) begin
      pc_mem[req.pc_waddr] <= req.pc_wdata;
    end
    pc_rd <= pc_mem[req.pc_raddr];
    pc_rv <= pc_vld[req.pc_raddr];
  end

  // Successor list heads.
  always_ff @(posedge clk) begin
    if (req.lh_we) begin
      lh_mem[req.lh_waddr] <= req.lh_wdata;
    end
    lh_rd <= lh_mem[req.lh_raddr];
    lh_rv <= lh_vld[req.lh_raddr];
  end

  // Edge pool: target node and link to the next edge.
  always_ff @(posedge clk) begin
    if (req.eg_we) begin
      et_mem[req.eg_waddr] <= req.et_wdata;
      en_mem[req.eg_waddr] <= req.en_wdata;
    end
    et_rd <= et_mem[req.eg_raddr];
    en_rd <= en_mem[req.eg_raddr];
  end

  // Ready queue links; entry zero holds the queue head.
  always_ff @(posedge clk) begin
    if (req.ql_we) begin
      ql_mem[req.ql_waddr] <= req.ql_wdata;
    end
    ql_rd <= ql_mem[req.ql_raddr];
  end

  assign rsp.pc_rdata  = pc_rv ? pc_rd : '0;
  assign rsp.lh_rdata  = lh_rv ? lh_rd : '0;
  assign rsp.et_rdata  = et_rd;
  assign rsp.en_rdata  = en_rd;
  assign rsp.ql_rdata  = ql_rd;
  assign rsp.scan_zero = ~pc_vld[req.scan_addr];

endmodule

// ===== src/topological_sort_engine.sv =====
// Channel  Handshake            Payload                        Direction
// cfg      cfg_valid/cfg_ready  node_count                     in
// in       in_valid/in_ready    mode, pred_node, succ_node     in
// out      out_valid/out_ready  node, last, cycle, dropped     out
//
// A relation word reads the tables in S_IDLE and updates them in S_REL.
// A start word scans nodes 1 to node_count for a zero predecessor count, fetches the
// queue head, then walks each emitted node's successor edges, decrementing counts.
// Reset is synchronous; entry valid bits clear the count and list head tables at once,
// so no clearing pass. A result waits in the output register; the sequencer stalls only
// when it has the next result ready and the previous one has not yet been taken.
module topological_sort_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          node_count,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [5:0]          pred_node,
  input  logic [5:0]          succ_node,
  output logic                out_valid,
  input  logic                out_ready,
  output tse_pkg::node_t      node,
  output logic                last,
  output logic                cycle,
  output logic                dropped
);
  import tse_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_REL     = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_FIRST   = 4'd3;
  localparam logic [3:0] S_LINK    = 4'd4;
  localparam logic [3:0] S_HEAD_RD = 4'd5;
  localparam logic [3:0] S_HEAD    = 4'd6;
  localparam logic [3:0] S_EDGE    = 4'd7;
  localparam logic [3:0] S_TGT     = 4'd8;
  localparam logic [3:0] S_DEC     = 4'd9;
  localparam logic [3:0] S_NEXT    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  node_t      n_nodes;
  node_t      j_q;
  node_t      k_q;
  node_t      f;
  node_t      tail;
  node_t      s_q;
  node_t      scan_i;
  node_t      emitted;
  elink_t     p;
  elink_t     edges_used;
  logic       dropped_flag;

  tbl_req_t   req;
  tbl_rsp_t   rsp;

  node_t           n_eff;
  logic            out_free;
  logic            accept;
  logic            rel_ok;
  logic [NODE_W:0] cnt_next;
  logic            fin;

  tse_tables u_tables (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // The node count is taken only while no word is being worked on.
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign n_eff = (n_nodes > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : n_nodes;

  // A relation is kept only with both nodes in range, a free edge and room in the count.
  assign rel_ok = (j_q != '0) && (j_q <= n_eff) && (k_q != '0) && (k_q <= n_eff) &&
                  (edges_used < ELINK_W'(MAX_EDGES)) && (rsp.pc_rdata != CNT_W'(CNT_MAX));

  // The current node is the last one when nothing follows it in the queue or the emitted count reaches the node count.
  assign cnt_next = {1'b0, emitted} + 1'b1;
  assign fin      = (f == tail) || (cnt_next >= {1'b0, n_eff});

  // Table requests and next state.
  always_comb begin
    req        = '0;
    state_next = state;
    req.scan_addr = scan_i;
    unique case (state)
      S_IDLE: begin
        req.pc_raddr = succ_node;
        req.lh_raddr = pred_node;
        if (accept) begin
          if (!mode) begin
            state_next = S_REL;
          end else if (n_eff == '0) begin
            state_next = S_FIRST;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_REL: begin
        if (rel_ok) begin
          req.pc_we    = 1'b1;
          req.pc_waddr = k_q;
          req.pc_wdata = rsp.pc_rdata + 1'b1;
          req.eg_we    = 1'b1;
          req.eg_waddr = EIDX_W'(edges_used);
          req.et_wdata = k_q;
          req.en_wdata = rsp.lh_rdata;
          req.lh_we    = 1'b1;
          req.lh_waddr = j_q;
          req.lh_wdata = ELINK_W'(edges_used + 1'b1);
        end
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (rsp.scan_zero) begin
          req.ql_we    = 1'b1;
          req.ql_waddr = tail;
          req.ql_wdata = scan_i;
        end
        if (scan_i == n_eff) begin
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        if (tail == '0) begin
          if (out_free) begin
            req.clear  = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          req.ql_raddr = '0;
          state_next   = S_LINK;
        end
      end
      S_LINK: begin
        state_next = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        req.lh_raddr = f;
        state_next   = S_HEAD;
      end
      S_HEAD: begin
        state_next = S_EDGE;
      end
      S_EDGE: begin
        if (p == '0) begin
          state_next = S_NEXT;
        end else begin
          req.eg_raddr = EIDX_W'(p - 1'b1);
          state_next   = S_TGT;
        end
      end
      S_TGT: begin
        req.pc_raddr = rsp.et_rdata;
        state_next   = S_DEC;
      end
      S_DEC: begin
        if (rsp.pc_rdata != '0) begin
          req.pc_we    = 1'b1;
          req.pc_waddr = s_q;
          req.pc_wdata = rsp.pc_rdata - 1'b1;
          if (rsp.pc_rdata == CNT_W'(1)) begin
            req.ql_we    = 1'b1;
            req.ql_waddr = tail;
            req.ql_wdata = s_q;
          end
        end
        state_next = S_EDGE;
      end
      S_NEXT: begin
        if (out_free) begin
          if (fin) begin
            req.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            req.ql_raddr = f;
            state_next   = S_LINK;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      n_nodes      <= '0;
      edges_used   <= '0;
      dropped_flag <= 1'b0;
      tail         <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        n_nodes <= node_count;
      end
      if (state == S_REL) begin
        if (rel_ok) begin
          edges_used <= edges_used + 1'b1;
        end else begin
          dropped_flag <= 1'b1;
        end
      end
      if (accept) begin
        tail <= '0;
      end else if (req.ql_we) begin
        tail <= req.ql_wdata;
      end
      if (req.clear) begin
        edges_used   <= '0;
        dropped_flag <= 1'b0;
      end
      if ((state == S_FIRST && tail == '0 && out_free) || (state == S_NEXT && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    if (accept) begin
      j_q     <= pred_node;
      k_q     <= succ_node;
      scan_i  <= NODE_W'(1);
      emitted <= '0;
    end
    if (state == S_SCAN) begin
      scan_i <= scan_i + 1'b1;
    end
    if (state == S_LINK) begin
      f <= rsp.ql_rdata;
    end
    if (state == S_HEAD) begin
      p <= rsp.lh_rdata;
    end
    if (state == S_TGT) begin
      s_q <= rsp.et_rdata;
      p   <= rsp.en_rdata;
    end
    if (state == S_NEXT && out_free) begin
      emitted <= cnt_next[NODE_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state == S_FIRST && tail == '0 && out_free) begin
      node    <= '0;
      last    <= 1'b1;
      cycle   <= (n_eff != '0);
      dropped <= dropped_flag;
    end else if (state == S_NEXT && out_free) begin
      node    <= f;
      last    <= fin;
      cycle   <= fin && (cnt_next < {1'b0, n_eff});
      dropped <= fin && dropped_flag;
    end
  end

endmodule
